// ----- design/vertex_rotate_backface_cull_core_defines.svh -----
// Assertion macros for the vertex rotate / backface cull core.
// Both sample on clk and are off while arst_n is low.
`ifndef VERTEX_ROTATE_BACKFACE_CULL_CORE_DEFINES_SVH
`define VERTEX_ROTATE_BACKFACE_CULL_CORE_DEFINES_SVH

// same-cycle implication
`define VRBC_ASSERT_IMP(name, ante, cons) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("vrbc: same-cycle check failed");

// next-cycle implication
`define VRBC_ASSERT_NXT(name, ante, cons) \
name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("vrbc: next-cycle check failed");

`endif

// ----- design/vrbc_pkg.sv -----
package vrbc_pkg;

	typedef logic signed [15:0] in_coord_t;
	typedef logic signed [16:0] coord_t;
	typedef logic signed [19:0] wide_coord_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} vertex_t;

	localparam int VTX_DEPTH = 256;
	localparam int VTX_AW = $clog2(VTX_DEPTH);

	localparam logic CMD_VERTEX = 1'b0;
	localparam logic CMD_TRIANGLE = 1'b1;

	localparam logic [2:0] REG_COS_X = 3'd0;
	localparam logic [2:0] REG_SIN_X = 3'd1;
	localparam logic [2:0] REG_COS_Y = 3'd2;
	localparam logic [2:0] REG_SIN_Y = 3'd3;
	localparam logic [2:0] REG_CAM_X = 3'd4;
	localparam logic [2:0] REG_CAM_Y = 3'd5;
	localparam logic [2:0] REG_CAM_Z = 3'd6;

	localparam in_coord_t ONE_Q14 = 16'sd16384;
	localparam wide_coord_t Z_OFFSET = 20'sd768;
	localparam wide_coord_t SAT_HI = 20'sd65535;
	localparam wide_coord_t SAT_LO = -20'sd65536;
	localparam coord_t COORD_MAX = 17'sh0FFFF;
	localparam coord_t COORD_MIN = 17'sh10000;

	function automatic coord_t sat17(input wide_coord_t v);
		coord_t r;
		if (v > SAT_HI) begin
			r = COORD_MAX;
		end else if (v < SAT_LO) begin
			r = COORD_MIN;
		end else begin
			r = v[16:0];
		end
		return r;
	endfunction

endpackage

// ----- design/vertex_rotate_backface_cull_core.sv -----
// One item in flight at a time; the core takes a new input only while idle.
// The steps are set by the single shared multiply-accumulate unit, plus three reads of the
// vertex store's single read port for a triangle. The result register frees the input side early.
// The last step waits while a previous result is still held unaccepted at the output.
// Reset clears control state and config registers (cos 1.0, sin 0, camera 0).
// The vertex store is not cleared; reading a never-written slot returns garbage.
`include "vertex_rotate_backface_cull_core_defines.svh"

module vertex_rotate_backface_cull_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [2:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [7:0]           vertex_index,
	input  vrbc_pkg::in_coord_t  vertex_x,
	input  vrbc_pkg::in_coord_t  vertex_y,
	input  vrbc_pkg::in_coord_t  vertex_z,
	input  logic [7:0]           index_a,
	input  logic [7:0]           index_b,
	input  logic [7:0]           index_c,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 kind,
	output vrbc_pkg::coord_t     out_x,
	output vrbc_pkg::coord_t     out_y,
	output vrbc_pkg::coord_t     out_z,
	output logic                 visible
);
	import vrbc_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_RUN = 1'b1;

	localparam logic [3:0] VTX_LAST = 4'd9;
	localparam logic [3:0] TRI_LAST = 4'd14;

	localparam logic [1:0] ACC_NONE = 2'd0;
	localparam logic [1:0] ACC_LOAD = 2'd1;
	localparam logic [1:0] ACC_ADD = 2'd2;
	localparam logic [1:0] ACC_SUB = 2'd3;

	logic state_q;
	logic [3:0] step_q;
	logic cmd_q;

	in_coord_t cos_x_q, sin_x_q, cos_y_q, sin_y_q;
	in_coord_t cam_x_q, cam_y_q, cam_z_q;

	logic [VTX_AW-1:0] vidx_q, idx_a_q, idx_b_q, idx_c_q;
	in_coord_t vx_q, vy_q, vz_q;

	vertex_t vstore_mem [VTX_DEPTH];
	vertex_t rd_data_q;
	logic [VTX_AW-1:0] rd_addr;
	logic mem_we;
	vertex_t wr_data;

	logic signed [36:0] mul_a;
	logic signed [17:0] mul_b;
	logic signed [54:0] prod_q;
	logic signed [56:0] acc_q;
	logic [1:0] acc_op;
	wide_coord_t acc_sh;
	logic signed [17:0] z1_now;
	logic signed [17:0] z1_q;
	coord_t ox_q, oy_q, oz_c;

	vertex_t a_q, b_q;
	logic signed [17:0] u0_q, u1_q, u2_q, v0_q, v1_q, v2_q, w0_q, w1_q, w2_q;
	logic signed [36:0] n0_q, n1_q, n2_q;

	logic run, vtx_run, tri_run, last, out_free, finish, in_xfer;

	logic out_valid_q, kind_q, visible_q;
	coord_t out_x_q, out_y_q, out_z_q;

	assign run = (state_q == ST_RUN);
	assign vtx_run = run && (cmd_q == CMD_VERTEX);
	assign tri_run = run && (cmd_q == CMD_TRIANGLE);
	assign last = (cmd_q == CMD_VERTEX) ? (step_q == VTX_LAST) : (step_q == TRI_LAST);
	assign out_free = !out_valid_q || out_ready;
	assign finish = run && last && out_free;
	assign in_ready = (state_q == ST_IDLE);
	assign in_xfer = in_valid && in_ready;

	assign acc_sh = acc_q[33:14];
	assign z1_now = acc_q[31:14];
	assign oz_c = sat17(acc_sh + Z_OFFSET);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_xfer) begin
				state_q <= ST_RUN;
				step_q <= '0;
			end else if (finish) begin
				state_q <= ST_IDLE;
			end else if (run && !last) begin
				step_q <= step_q + 4'd1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cos_x_q <= ONE_Q14;
			sin_x_q <= '0;
			cos_y_q <= ONE_Q14;
			sin_y_q <= '0;
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COS_X: cos_x_q <= cfg_data;
				REG_SIN_X: sin_x_q <= cfg_data;
				REG_COS_Y: cos_y_q <= cfg_data;
				REG_SIN_Y: sin_y_q <= cfg_data;
				REG_CAM_X: cam_x_q <= cfg_data;
				REG_CAM_Y: cam_y_q <= cfg_data;
				REG_CAM_Z: cam_z_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// step decode: multiplier operands, accumulator op, store read address
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		acc_op = ACC_NONE;
		rd_addr = idx_a_q;
		case (cmd_q)
			CMD_VERTEX: begin
				case (step_q)
					4'd0: begin mul_a = 37'(vy_q); mul_b = 18'(cos_x_q); end
					4'd1: begin mul_a = 37'(vz_q); mul_b = 18'(sin_x_q); acc_op = ACC_LOAD; end
					4'd2: begin mul_a = 37'(vy_q); mul_b = 18'(sin_x_q); acc_op = ACC_SUB; end
					4'd3: begin mul_a = 37'(vz_q); mul_b = 18'(cos_x_q); acc_op = ACC_LOAD; end
					4'd4: begin mul_a = 37'(vx_q); mul_b = 18'(cos_y_q); acc_op = ACC_ADD; end
					4'd5: begin mul_a = 37'(z1_now); mul_b = 18'(sin_y_q); acc_op = ACC_LOAD; end
					4'd6: begin mul_a = 37'(vx_q); mul_b = 18'(sin_y_q); acc_op = ACC_SUB; end
					4'd7: begin mul_a = 37'(z1_q); mul_b = 18'(cos_y_q); acc_op = ACC_LOAD; end
					4'd8: acc_op = ACC_ADD;
					default: ;
				endcase
			end
			CMD_TRIANGLE: begin
				case (step_q)
					4'd0: rd_addr = idx_a_q;
					4'd1: rd_addr = idx_b_q;
					4'd2: rd_addr = idx_c_q;
					4'd4: begin mul_a = 37'(v1_q); mul_b = u2_q; end
					4'd5: begin mul_a = 37'(v2_q); mul_b = u1_q; acc_op = ACC_LOAD; end
					4'd6: begin mul_a = 37'(v2_q); mul_b = u0_q; acc_op = ACC_SUB; end
					4'd7: begin mul_a = 37'(v0_q); mul_b = u2_q; acc_op = ACC_LOAD; end
					4'd8: begin mul_a = 37'(v0_q); mul_b = u1_q; acc_op = ACC_SUB; end
					4'd9: begin mul_a = 37'(v1_q); mul_b = u0_q; acc_op = ACC_LOAD; end
					4'd10: begin mul_a = n0_q; mul_b = w0_q; acc_op = ACC_SUB; end
					4'd11: begin mul_a = n1_q; mul_b = w1_q; acc_op = ACC_LOAD; end
					4'd12: begin mul_a = n2_q; mul_b = w2_q; acc_op = ACC_ADD; end
					4'd13: acc_op = ACC_ADD;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	// vertex store
	assign mem_we = finish && (cmd_q == CMD_VERTEX);
	assign wr_data = '{x: ox_q, y: oy_q, z: oz_c};

	always_ff @(posedge clk) begin
		if (mem_we) begin
			vstore_mem[vidx_q] <= wr_data;
		end
		rd_data_q <= vstore_mem[rd_addr];
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q <= cmd;
			vidx_q <= vertex_index[VTX_AW-1:0];
			idx_a_q <= index_a[VTX_AW-1:0];
			idx_b_q <= index_b[VTX_AW-1:0];
			idx_c_q <= index_c[VTX_AW-1:0];
			vx_q <= vertex_x;
			vy_q <= vertex_y;
			vz_q <= vertex_z;
		end

		prod_q <= mul_a * mul_b;
		case (acc_op)
			ACC_LOAD: acc_q <= {{2{prod_q[54]}}, prod_q};
			ACC_ADD: acc_q <= acc_q + {{2{prod_q[54]}}, prod_q};
			ACC_SUB: acc_q <= acc_q - {{2{prod_q[54]}}, prod_q};
			default: ;
		endcase

		if (vtx_run && step_q == 4'd3) oy_q <= sat17(acc_sh);
		if (vtx_run && step_q == 4'd5) z1_q <= z1_now;
		if (vtx_run && step_q == 4'd7) ox_q <= sat17(acc_sh);

		if (tri_run && step_q == 4'd1) a_q <= rd_data_q;
		if (tri_run && step_q == 4'd2) b_q <= rd_data_q;
		if (tri_run && step_q == 4'd3) begin
			u0_q <= 18'(b_q.x) - 18'(a_q.x);
			u1_q <= 18'(b_q.y) - 18'(a_q.y);
			u2_q <= 18'(b_q.z) - 18'(a_q.z);
			v0_q <= 18'(rd_data_q.x) - 18'(a_q.x);
			v1_q <= 18'(rd_data_q.y) - 18'(a_q.y);
			v2_q <= 18'(rd_data_q.z) - 18'(a_q.z);
			w0_q <= 18'(a_q.x) - 18'(cam_x_q);
			w1_q <= 18'(a_q.y) - 18'(cam_y_q);
			w2_q <= 18'(a_q.z) - 18'(cam_z_q);
		end
		if (tri_run && step_q == 4'd7) n0_q <= acc_q[36:0];
		if (tri_run && step_q == 4'd9) n1_q <= acc_q[36:0];
		if (tri_run && step_q == 4'd11) n2_q <= acc_q[36:0];

		if (finish) begin
			kind_q <= cmd_q;
			if (cmd_q == CMD_VERTEX) begin
				out_x_q <= ox_q;
				out_y_q <= oy_q;
				out_z_q <= oz_c;
				visible_q <= 1'b0;
			end else begin
				out_x_q <= '0;
				out_y_q <= '0;
				out_z_q <= '0;
				visible_q <= acc_q[56];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign out_x = out_x_q;
	assign out_y = out_y_q;
	assign out_z = out_z_q;
	assign visible = visible_q;

	`VRBC_ASSERT_NXT(a_transfer_starts_run, in_xfer, state_q == ST_RUN && step_q == '0)
	`VRBC_ASSERT_IMP(a_store_write_at_end, mem_we, vtx_run && step_q == VTX_LAST)
	`VRBC_ASSERT_IMP(a_step_in_range, run, step_q <= TRI_LAST && (tri_run || step_q <= VTX_LAST))
	`VRBC_ASSERT_NXT(a_finish_gives_result, finish, out_valid_q && state_q == ST_IDLE)

endmodule
